@@ src/twg_pkg.sv @@
`default_nettype none

package twg_pkg;

   // Field widths
   localparam int IDX_W = 12;
   localparam int LEN_W = 13;
   localparam int VAL_W = 16;
   localparam int REG_W = 2;

   // Window length limits
   localparam logic [LEN_W-1:0] MAX_POINTS   = 13'd4096;
   localparam logic [LEN_W-1:0] RESET_LENGTH = 13'd1024;

   // Flat centre: 2*ceil(N*625/3072), with /3072 done as >>10 and then /3 by reciprocal
   localparam int SCALED_W     = 23;
   localparam int CEIL_W       = 12;
   localparam int CEIL_SHIFT   = 10;
   localparam int THIRD_W      = 24;
   localparam int THIRD_SHIFT  = 13;
   localparam int HALF_CTR_W   = THIRD_W - THIRD_SHIFT;
   localparam logic [SCALED_W-1:0] FLAT_MUL  = 23'd625;
   localparam logic [SCALED_W-1:0] CEIL_BIAS = 23'd3071;
   localparam logic [THIRD_W-1:0]  THIRD_MUL = 24'd2731;

   // Settle time of the derived window constants after a write or reset
   localparam int SETTLE_W = 2;
   localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

   // Divider: numerator k*N, denominator c*(N-1), 30 quotient bits
   localparam int PROD_W = IDX_W + LEN_W;
   localparam int DEN_W  = IDX_W + LEN_W;
   localparam int Q_W    = 30;

   // Cosine polynomial in Q30
   localparam int U_W      = 29;
   localparam int COEF_W   = 33;
   localparam int MUL_W    = U_W + COEF_W;
   localparam int HORNER_N = 6;
   localparam logic [Q_W:0]   Q30_ONE  = 31'd1073741824;
   localparam logic [Q_W-1:0] Q30_HALF = 30'd536870912;
   localparam int VAL_SHIFT = 15;
   localparam logic [Q_W+1:0] ROUND_HALF = 32'd16384;
   localparam logic [VAL_W-1:0] VALUE_ONE = 16'd32768;

   // pi^(2k)/(2k)! in Q30, lowest order first
   localparam logic [COEF_W-1:0] COS_COEF [HORNER_N] = '{
      33'd5298703516,
      33'd4358008962,
      33'd1433727481,
      33'd252684340,
      33'd27709939,
      33'd2071865
   };

   typedef enum logic [REG_W-1:0] {
      REGION_RISE = 2'd0,
      REGION_FLAT = 2'd1,
      REGION_FALL = 2'd2
   } region_type;

   // Window constants derived from the length register
   typedef struct packed {
      logic [LEN_W-1:0] n;
      logic [IDX_W-1:0] c;
      logic [LEN_W-1:0] flat_end;
      logic [LEN_W-1:0] fall_end;
      logic [DEN_W-1:0] den;
   } cfg_type;

   // Classification that travels with each request
   typedef struct packed {
      logic       oor;
      region_type region;
      logic       taper;
   } meta_type;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      region_type       region;
      logic             oor;
   } rsp_type;

endpackage

`default_nettype wire

@@ src/twg_cfg.sv @@
`default_nettype none

module twg_cfg import twg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic [LEN_W-1:0] csr_window_length,
   output logic             csr_ready,
   output cfg_type          cfg,
   output logic             settled
);

   logic [LEN_W-1:0]    window_length_ff, window_length_in;
   logic [SETTLE_W-1:0] settle_ff, settle_in;
   logic [LEN_W-1:0]    n_a_ff, n_a_in;
   logic [CEIL_W-1:0]   ceil_a_ff, ceil_a_in;
   logic [LEN_W-1:0]    n_b_ff, n_b_in;
   logic [IDX_W-1:0]    c_b_ff, c_b_in;
   logic [LEN_W-1:0]    flat_end_b_ff, flat_end_b_in;
   logic [LEN_W-1:0]    fall_end_b_ff, fall_end_b_in;
   cfg_type             cfg_ff, cfg_in;

   logic [SCALED_W-1:0]   scaled;
   logic [THIRD_W-1:0]    third_prod;
   logic [LEN_W-1:0]      centre_raw;
   logic [LEN_W-1:0]      centre;
   logic [LEN_W-1:0]      taper_pair;
   logic                  csr_take;

   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   // Capture the length register and restart the settle count
   always_comb begin
      window_length_in = csr_take ? csr_window_length : window_length_ff;
      if (csr_take) begin
         settle_in = SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= RESET_LENGTH;
         settle_ff        <= SETTLE_CYCLES;
      end else begin
         window_length_ff <= window_length_in;
         settle_ff        <= settle_in;
      end
   end

   assign settled = (settle_ff == '0);

   // Saturate N and form ceil(N*625/3072) up to the final divide by 3
   always_comb begin
      n_a_in    = (window_length_ff > MAX_POINTS) ? MAX_POINTS : window_length_ff;
      scaled    = SCALED_W'(n_a_in) * FLAT_MUL + CEIL_BIAS;
      ceil_a_in = scaled[CEIL_SHIFT +: CEIL_W];
   end

   // Divide by 3, clamp the centre and split the remainder into two tapers
   always_comb begin
      third_prod    = THIRD_W'(ceil_a_ff) * THIRD_MUL;
      centre_raw    = {1'b0, third_prod[THIRD_SHIFT +: HALF_CTR_W], 1'b0};
      centre        = (centre_raw > n_a_ff) ? n_a_ff : centre_raw;
      taper_pair    = n_a_ff - centre;
      n_b_in        = n_a_ff;
      c_b_in        = taper_pair[IDX_W:1];
      flat_end_b_in = LEN_W'(c_b_in) + centre;
      fall_end_b_in = flat_end_b_in + LEN_W'(c_b_in);
   end

   // Taper denominator c*(N-1)
   always_comb begin
      cfg_in.n        = n_b_ff;
      cfg_in.c        = c_b_ff;
      cfg_in.flat_end = flat_end_b_ff;
      cfg_in.fall_end = fall_end_b_ff;
      cfg_in.den      = DEN_W'(c_b_ff) * DEN_W'(n_b_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      n_a_ff        <= n_a_in;
      ceil_a_ff     <= ceil_a_in;
      n_b_ff        <= n_b_in;
      c_b_ff        <= c_b_in;
      flat_end_b_ff <= flat_end_b_in;
      fall_end_b_ff <= fall_end_b_in;
      cfg_ff        <= cfg_in;
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ src/twg_front.sv @@
`default_nettype none

module twg_front import twg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [IDX_W-1:0]  coeff_index,
   input  cfg_type           cfg,
   output logic              out_valid,
   output meta_type          out_meta,
   output logic [PROD_W-1:0] out_prod
);

   logic              s1_valid_ff, s1_valid_in;
   meta_type          s1_meta_ff, s1_meta_in;
   logic [IDX_W-1:0]  s1_k_ff, s1_k_in;
   logic              s2_valid_ff;
   meta_type          s2_meta_ff;
   logic [PROD_W-1:0] s2_prod_ff, s2_prod_in;

   logic [LEN_W-1:0] idx;
   logic [LEN_W-1:0] mirror;

   // Classify the index and fold the falling taper onto the rising one
   always_comb begin
      idx               = LEN_W'(coeff_index);
      mirror            = cfg.fall_end - 1'b1 - idx;
      s1_valid_in       = in_valid;
      s1_meta_in.oor    = 1'b0;
      s1_meta_in.region = REGION_RISE;
      s1_meta_in.taper  = 1'b0;
      s1_k_in           = coeff_index;
      priority if (idx >= cfg.n) begin
         s1_meta_in.oor = 1'b1;
      end else if (idx < LEN_W'(cfg.c)) begin
         s1_meta_in.taper = 1'b1;
      end else if (idx < cfg.flat_end) begin
         s1_meta_in.region = REGION_FLAT;
      end else begin
         s1_meta_in.region = REGION_FALL;
         s1_meta_in.taper  = (idx < cfg.fall_end);
         s1_k_in           = mirror[IDX_W-1:0];
      end
   end

   // Numerator of the taper phase: k*N
   assign s2_prod_in = PROD_W'(s1_k_ff) * PROD_W'(cfg.n);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_meta_ff <= s1_meta_in;
         s1_k_ff    <= s1_k_in;
         s2_meta_ff <= s1_meta_ff;
         s2_prod_ff <= s2_prod_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_meta  = s2_meta_ff;
   assign out_prod  = s2_prod_ff;

endmodule

`default_nettype wire

@@ src/twg_div.sv @@
`default_nettype none

module twg_div import twg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [DEN_W-1:0]  den,
   input  logic              in_valid,
   input  meta_type          in_meta,
   input  logic [PROD_W-1:0] in_num,
   output logic              out_valid,
   output meta_type          out_meta,
   output logic [Q_W-1:0]    out_quot
);

   logic [DEN_W-1:0] rem_ff   [Q_W];
   logic [Q_W-1:0]   quot_ff  [Q_W];
   meta_type         meta_ff  [Q_W];
   logic             valid_ff [Q_W];

   // One restoring step per stage: shift, compare, subtract
   for (genvar g = 0; g < Q_W; g++) begin : g_step
      logic [DEN_W-1:0] rem_src;
      logic [Q_W-1:0]   quot_src;
      meta_type         meta_src;
      logic             valid_src;
      logic [DEN_W:0]   rem_shift;
      logic [DEN_W:0]   rem_sub;
      logic             take;
      logic [DEN_W-1:0] rem_in;
      logic [Q_W-1:0]   quot_in;

      if (g == 0) begin : g_first
         assign rem_src   = DEN_W'(in_num);
         assign quot_src  = '0;
         assign meta_src  = in_meta;
         assign valid_src = in_valid;
      end else begin : g_next
         assign rem_src   = rem_ff[g-1];
         assign quot_src  = quot_ff[g-1];
         assign meta_src  = meta_ff[g-1];
         assign valid_src = valid_ff[g-1];
      end

      always_comb begin
         rem_shift = {rem_src, 1'b0};
         rem_sub   = rem_shift - {1'b0, den};
         take      = (rem_shift >= {1'b0, den});
         rem_in    = take ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
         quot_in   = {quot_src[Q_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (advance) begin
            valid_ff[g] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[g]  <= rem_in;
            quot_ff[g] <= quot_in;
            meta_ff[g] <= meta_src;
         end
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign out_meta  = meta_ff[Q_W-1];
   assign out_quot  = quot_ff[Q_W-1];

endmodule

`default_nettype wire

@@ src/twg_cos.sv @@
`default_nettype none

module twg_cos import twg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           in_valid,
   input  meta_type       in_meta,
   input  logic [Q_W-1:0] in_phase,
   output logic           out_valid,
   output rsp_type        out_rsp
);

   // Fold stage
   logic           f_valid_ff;
   meta_type       f_meta_ff;
   logic           f_hi_ff, f_hi_in;
   logic [Q_W-1:0] f_t_ff, f_t_in;

   // Square stage
   logic               q_valid_ff;
   meta_type           q_meta_ff;
   logic               q_hi_ff;
   logic [U_W-1:0]     q_u_ff, q_u_in;
   logic [2*Q_W-1:0]   sq_prod;

   // Horner stages
   logic              h_valid_ff [HORNER_N];
   meta_type          h_meta_ff  [HORNER_N];
   logic              h_hi_ff    [HORNER_N];
   logic [U_W-1:0]    h_u_ff     [HORNER_N];
   logic [COEF_W-1:0] h_p_ff     [HORNER_N];

   // Output stage
   logic            o_valid_ff;
   rsp_type         o_rsp_ff, o_rsp_in;
   logic [Q_W:0]    cos_val;
   logic [Q_W+1:0]  v_sum;
   logic [Q_W+1:0]  rnd_sum;

   // Fold the phase around one half
   always_comb begin
      f_hi_in = (in_phase > Q30_HALF);
      f_t_in  = f_hi_in ? Q_W'(Q30_ONE - (Q_W+1)'(in_phase)) : in_phase;
   end

   // Square the folded phase in Q30
   always_comb begin
      sq_prod = (2*Q_W)'(f_t_ff) * (2*Q_W)'(f_t_ff);
      q_u_in  = sq_prod[Q_W +: U_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         q_valid_ff <= 1'b0;
      end else if (advance) begin
         f_valid_ff <= in_valid;
         q_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f_meta_ff <= in_meta;
         f_hi_ff   <= f_hi_in;
         f_t_ff    <= f_t_in;
         q_meta_ff <= f_meta_ff;
         q_hi_ff   <= f_hi_ff;
         q_u_ff    <= q_u_in;
      end
   end

   // Horner steps, highest order term first, floored at zero
   for (genvar s = 0; s < HORNER_N; s++) begin : g_horner
      logic [COEF_W-1:0] h_term;
      logic [MUL_W-1:0]  h_prod;
      logic [U_W-1:0]    u_src;
      meta_type          meta_src;
      logic              hi_src;
      logic              valid_src;

      if (s == 0) begin : g_first
         assign h_term    = COS_COEF[HORNER_N-1];
         assign u_src     = q_u_ff;
         assign meta_src  = q_meta_ff;
         assign hi_src    = q_hi_ff;
         assign valid_src = q_valid_ff;
      end else begin : g_next
         assign h_term = (h_p_ff[s-1] > COS_COEF[HORNER_N-1-s]) ? '0 :
                         COS_COEF[HORNER_N-1-s] - h_p_ff[s-1];
         assign u_src     = h_u_ff[s-1];
         assign meta_src  = h_meta_ff[s-1];
         assign hi_src    = h_hi_ff[s-1];
         assign valid_src = h_valid_ff[s-1];
      end

      assign h_prod = MUL_W'(u_src) * MUL_W'(h_term);

      always_ff @(posedge clock) begin
         if (reset) begin
            h_valid_ff[s] <= 1'b0;
         end else if (advance) begin
            h_valid_ff[s] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            h_meta_ff[s] <= meta_src;
            h_hi_ff[s]   <= hi_src;
            h_u_ff[s]    <= u_src;
            h_p_ff[s]    <= COEF_W'(h_prod >> Q_W);
         end
      end
   end

   // Finish the cosine, map to (1 -/+ cos)/2, round to Q1.15 and pick the value
   always_comb begin
      cos_val = (h_p_ff[HORNER_N-1] > COEF_W'(Q30_ONE)) ? '0 :
                (Q_W+1)'(COEF_W'(Q30_ONE) - h_p_ff[HORNER_N-1]);
      v_sum   = h_hi_ff[HORNER_N-1] ? ((Q_W+2)'(Q30_ONE) + (Q_W+2)'(cos_val)) :
                                      ((Q_W+2)'(Q30_ONE) - (Q_W+2)'(cos_val));
      rnd_sum = (v_sum >> 1) + ROUND_HALF;
      o_rsp_in.region = h_meta_ff[HORNER_N-1].region;
      o_rsp_in.oor    = h_meta_ff[HORNER_N-1].oor;
      priority if (h_meta_ff[HORNER_N-1].taper) begin
         o_rsp_in.value = rnd_sum[VAL_SHIFT +: VAL_W];
      end else if (!h_meta_ff[HORNER_N-1].oor &&
                   h_meta_ff[HORNER_N-1].region == REGION_FLAT) begin
         o_rsp_in.value = VALUE_ONE;
      end else begin
         o_rsp_in.value = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (advance) begin
         o_valid_ff <= h_valid_ff[HORNER_N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         o_rsp_ff <= o_rsp_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_rsp   = o_rsp_ff;

endmodule

`default_nettype wire

@@ src/tukey_window_coefficient_generator.sv @@
// Pipeline: a result passes 2 index stages, 30 divider stages, 9 cosine stages and the
//   output register, and may wait in the skid register. Throughput: one request per
//   cycle while the skid register is free; the 30-stage restoring divider sets the depth.
// Reset: synchronous, active high; length returns to 1024 and req_ready stays low after
//   reset or a csr write while the derived window constants settle.
`default_nettype none

module tukey_window_coefficient_generator import twg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [IDX_W-1:0] req_coeff_index,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [VAL_W-1:0] rsp_coeff_value,
   output logic [REG_W-1:0] rsp_region,
   output logic             rsp_out_of_range,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [LEN_W-1:0] csr_window_length
);

   cfg_type           cfg;
   logic              settled;
   logic              advance;

   logic              fr_valid;
   meta_type          fr_meta;
   logic [PROD_W-1:0] fr_prod;

   logic              dv_valid;
   meta_type          dv_meta;
   logic [Q_W-1:0]    dv_quot;

   logic              pipe_valid;
   rsp_type           pipe_rsp;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              skid_valid_ff, skid_valid_in;
   rsp_type           skid_ff;
   logic              load_out;
   logic              load_skid;
   logic              out_take;
   logic              emit;

   twg_cfg u_cfg (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_window_length (csr_window_length),
      .csr_ready         (csr_ready),
      .cfg               (cfg),
      .settled           (settled)
   );

   twg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_valid && settled),
      .coeff_index (req_coeff_index),
      .cfg         (cfg),
      .out_valid   (fr_valid),
      .out_meta    (fr_meta),
      .out_prod    (fr_prod)
   );

   twg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .den       (cfg.den),
      .in_valid  (fr_valid),
      .in_meta   (fr_meta),
      .in_num    (fr_prod),
      .out_valid (dv_valid),
      .out_meta  (dv_meta),
      .out_quot  (dv_quot)
   );

   twg_cos u_cos (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (dv_valid),
      .in_meta   (dv_meta),
      .in_phase  (dv_quot),
      .out_valid (pipe_valid),
      .out_rsp   (pipe_rsp)
   );

   // Advance the pipeline whenever the skid register is free
   assign advance   = !skid_valid_ff;
   assign req_ready = advance && settled;
   assign out_take  = rsp_valid_ff && rsp_ready;
   assign emit      = advance && pipe_valid;

   // Output register with one skid entry behind it
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_in        = pipe_rsp;
      load_out      = 1'b0;
      load_skid     = 1'b0;
      priority if (!rsp_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
            rsp_in        = skid_ff;
            load_out      = 1'b1;
         end else begin
            rsp_valid_in = emit;
            load_out     = emit;
         end
      end else if (emit) begin
         skid_valid_in = 1'b1;
         load_skid     = 1'b1;
      end else begin
         // Hold both registers
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_ff <= rsp_in;
      end
      if (load_skid) begin
         skid_ff <= pipe_rsp;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_coeff_value  = rsp_ff.value;
   assign rsp_region       = rsp_ff.region;
   assign rsp_out_of_range = rsp_ff.oor;

   // A waiting skid entry always has a result in front of it
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without an output result");

   // No request enters while the window constants settle
   a_no_take_unsettled: assert property (@(posedge clock) disable iff (reset)
      !settled |-> !req_ready)
      else $error("request accepted before window constants settled");

   // Out-of-range results carry a zero value in the rising region code
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_coeff_value == '0 && rsp_region == REGION_RISE))
      else $error("out-of-range result with nonzero value or region");

   // Flat centre always returns unity
   a_flat_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_region == REGION_FLAT) |-> (rsp_coeff_value == VALUE_ONE))
      else $error("flat centre result is not unity");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
module tb import twg_pkg::*;;

   // Taylor terms of cos(pi*t), pi^2k/(2k)! in Q30, lowest order first
   localparam longint unsigned TAYLOR_Q30 [6] = '{
      64'd5298703516, 64'd4358008962, 64'd1433727481,
      64'd252684340, 64'd27709939, 64'd2071865
   };
   localparam longint unsigned ONE_Q30  = 64'd1073741824;
   localparam longint unsigned HALF_Q30 = 64'd536870912;

   // Predicts each coefficient and holds the coefficients still owed by the block
   class coeff_scoreboard;
      rsp_type          expected_coeffs[$];
      logic [LEN_W-1:0] window_len;
      int               errors;

      function new();
         window_len = RESET_LENGTH;
         errors     = 0;
      endfunction

      function void set_length(logic [LEN_W-1:0] len);
         window_len = len;
      endfunction

      function int pending();
         return expected_coeffs.size();
      endfunction

      // Rising taper value in Q1.15 for taper index i < c
      function logic [VAL_W-1:0] taper_coeff(longint unsigned i, longint unsigned c,
                                             longint unsigned n);
         longint unsigned den, x, t, u, h, p, cv, v;
         int k;
         den = c * (n - 1);
         if (den == 0)
            return '0;
         x = ((i * n) << 30) / den;
         if (x >= ONE_Q30)
            x = ONE_Q30 - 1;
         t = (x <= HALF_Q30) ? x : ONE_Q30 - x;
         // Horner steps on t*t, each product truncated, floored at zero
         u = (t * t) >> 30;
         h = TAYLOR_Q30[5];
         for (k = 4; k >= 0; k--) begin
            p = (u * h) >> 30;
            h = (p > TAYLOR_Q30[k]) ? 0 : TAYLOR_Q30[k] - p;
         end
         p  = (u * h) >> 30;
         cv = (p > ONE_Q30) ? 0 : ONE_Q30 - p;
         v  = (x <= HALF_Q30) ? (ONE_Q30 - cv) >> 1 : (ONE_Q30 + cv) >> 1;
         return VAL_W'((v + 64'd16384) >> 15);
      endfunction

      // Work out the coefficient for an accepted request
      function void note_request(logic [IDX_W-1:0] idx);
         rsp_type         r;
         longint unsigned n, i, centre, c, j;
         n = (window_len > MAX_POINTS) ? MAX_POINTS : window_len;
         i = idx;
         r.value  = '0;
         r.region = REGION_RISE;
         r.oor    = 1'b0;
         if (i >= n) begin
            r.oor = 1'b1;
         end else begin
            centre = 2 * ((n * 625 + 3071) / 3072);
            if (centre > n)
               centre = n;
            c = (n - centre) / 2;
            if (i < c) begin
               r.value = taper_coeff(i, c, n);
            end else if (i < c + centre) begin
               r.region = REGION_FLAT;
               r.value  = VALUE_ONE;
            end else begin
               // Mirror the rising taper; an odd leftover last point gives zero
               j = i - (c + centre);
               r.region = REGION_FALL;
               if (j < c)
                  r.value = taper_coeff(c - 1 - j, c, n);
            end
         end
         expected_coeffs = {expected_coeffs, r};
      endfunction

      // Compare a result against the oldest outstanding coefficient
      function void check_result(logic [VAL_W-1:0] value, logic [REG_W-1:0] rgn,
                                 logic oor);
         rsp_type e;
         if (expected_coeffs.size() == 0) begin
            $error("unexpected result: coeff_value %0d region %0d out_of_range %0d",
                   value, rgn, oor);
            errors++;
            return;
         end
         e = expected_coeffs.pop_front();
         if (value !== e.value) begin
            $error("coeff_value mismatch: expected %0d, actual %0d", e.value, value);
            errors++;
         end
         if (rgn !== e.region) begin
            $error("region mismatch: expected %0d, actual %0d", e.region, rgn);
            errors++;
         end
         if (oor !== e.oor) begin
            $error("out_of_range mismatch: expected %0d, actual %0d", e.oor, oor);
            errors++;
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [IDX_W-1:0] req_coeff_index = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [VAL_W-1:0] rsp_coeff_value;
   logic [REG_W-1:0] rsp_region;
   logic             rsp_out_of_range;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [LEN_W-1:0] csr_window_length = '0;

   coeff_scoreboard  book = new();
   int               send_idle_pct  = 0;
   int               recv_stall_pct = 0;
   int               hold_cycles_req = 0;
   int               hold_left = 0;
   logic [LEN_W-1:0] cur_len = RESET_LENGTH;

   tukey_window_coefficient_generator DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_coeff_index   (req_coeff_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_coeff_value   (rsp_coeff_value),
      .rsp_region        (rsp_region),
      .rsp_out_of_range  (rsp_out_of_range),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_length (csr_window_length)
   );

   always #5 clock = ~clock;

   // Watch all three handshakes at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            book.set_length(csr_window_length);
         if (req_valid && req_ready)
            book.note_request(req_coeff_index);
         if (rsp_valid && rsp_ready)
            book.check_result(rsp_coeff_value, rsp_region, rsp_out_of_range);
      end
   end

   // Drive result ready: long hold-off when asked, else random stalls
   always @(negedge clock) begin
      if (hold_cycles_req > 0) begin
         hold_left       = hold_cycles_req;
         hold_cycles_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offer one request and hold it until accepted
   task automatic send_request(input logic [IDX_W-1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_coeff_index = idx;
      do
         @(posedge clock);
      while (!req_ready);
      @(negedge clock);
   endtask

   // Write the window length register
   task automatic write_length(input logic [LEN_W-1:0] len);
      req_valid         = 1'b0;
      csr_valid         = 1'b1;
      csr_window_length = len;
      do
         @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      cur_len   = len;
   endtask

   // Let every outstanding coefficient come back, then let the pipe settle
   task automatic drain();
      req_valid = 1'b0;
      while (book.pending() != 0)
         @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   // Pick an index, mostly inside the window
   function automatic logic [IDX_W-1:0] pick_index();
      int n;
      n = (cur_len > MAX_POINTS) ? int'(MAX_POINTS) : int'(cur_len);
      if (n == 0 || $urandom_range(99) < 15)
         return IDX_W'($urandom_range(4095));
      return IDX_W'($urandom_range(n - 1));
   endfunction

   initial begin
      #2000000;
      $display("tukey_window_coefficient_generator verification failed");
      $finish;
   end

   initial begin
      logic [LEN_W-1:0] len;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset length, taper edges, flat edges, last point, out of range
      send_request(12'd0);
      send_request(12'd151);
      send_request(12'd302);
      send_request(12'd303);
      send_request(12'd720);
      send_request(12'd721);
      send_request(12'd1023);
      send_request(12'd1024);
      send_request(12'd4095);
      drain();
      // Odd leftover point at the end of the falling taper
      write_length(13'd1023);
      send_request(12'd1021);
      send_request(12'd1022);
      drain();
      // Zero length: everything out of range
      write_length(13'd0);
      send_request(12'd0);
      send_request(12'd4095);
      drain();
      // Centre clamped to a single point
      write_length(13'd1);
      send_request(12'd0);
      send_request(12'd1);
      drain();
      // No taper at all
      write_length(13'd2);
      send_request(12'd0);
      send_request(12'd1);
      send_request(12'd2);
      drain();
      // No taper, odd leftover
      write_length(13'd3);
      send_request(12'd0);
      send_request(12'd1);
      send_request(12'd2);
      drain();
      // Register beyond the maximum saturates
      write_length(13'd8191);
      send_request(12'd0);
      send_request(12'd2047);
      send_request(12'd4095);
      drain();

      // Random segments across the idling modes
      for (int seg = 0; seg < 8; seg++) begin
         case (seg)
            0:       len = MAX_POINTS;
            2:       len = LEN_W'($urandom_range(2, 64));
            4:       len = LEN_W'($urandom_range(4097, 8191));
            6:       len = LEN_W'($urandom_range(16));
            default: len = LEN_W'($urandom_range(2, 4096));
         endcase
         case (seg / 2)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         write_length(len);
         for (int k = 0; k < 85; k++)
            send_request(pick_index());
         drain();
      end

      // Hold off results long enough to back the pipe up into the input
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_length(LEN_W'($urandom_range(2, 4096)));
      hold_cycles_req = 300;
      for (int k = 0; k < 120; k++)
         send_request(pick_index());
      drain();

      if (book.errors == 0)
         $display("tukey_window_coefficient_generator verification clean");
      else
         $display("tukey_window_coefficient_generator verification failed");
      $finish;
   end

endmodule
